FILE: rtl/core/lkcm_pkg.sv
package lkcm_pkg;

    localparam int TOKEN_DEPTH = 40;
    localparam int IDX_W       = $clog2(TOKEN_DEPTH);
    localparam int CHAR_W      = 8;
    localparam int CMD_W       = 3;
    localparam int NUM_KW      = 6;
    localparam int KW_SEL_W    = 3;
    localparam int KW_LEN_MIN  = 4;
    localparam int KW_LEN_MAX  = 6;

    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FORMAT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FILE    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_HELP    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;

    // Keyword order is the match priority: start, stop, status, format, file, help
    localparam logic [KW_SEL_W-1:0] KW_START  = 3'd0;
    localparam logic [KW_SEL_W-1:0] KW_STOP   = 3'd1;
    localparam logic [KW_SEL_W-1:0] KW_STATUS = 3'd2;
    localparam logic [KW_SEL_W-1:0] KW_FORMAT = 3'd3;
    localparam logic [KW_SEL_W-1:0] KW_FILE   = 3'd4;
    localparam logic [KW_SEL_W-1:0] KW_HELP   = 3'd5;

    typedef struct packed {
        logic                 start;
        logic                 step;
        logic [IDX_W-1:0]     len;
        logic [IDX_W-1:0]     idx;
        logic [CHAR_W-1:0]    data;
    } t_cmp_ctl;

    function automatic logic [IDX_W-1:0] kw_len(input logic [KW_SEL_W-1:0] k);
        logic [IDX_W-1:0] l;
        case (k)
            KW_START:  l = IDX_W'(5);
            KW_STOP:   l = IDX_W'(4);
            KW_STATUS: l = IDX_W'(6);
            KW_FORMAT: l = IDX_W'(6);
            KW_FILE:   l = IDX_W'(4);
            KW_HELP:   l = IDX_W'(4);
            default:   l = '0;
        endcase
        return l;
    endfunction

    // Characters are right-justified: the first character sits in the top byte used
    function automatic logic [KW_LEN_MAX*CHAR_W-1:0] kw_word(input logic [KW_SEL_W-1:0] k);
        logic [KW_LEN_MAX*CHAR_W-1:0] w;
        case (k)
            KW_START:  w = "start";
            KW_STOP:   w = "stop";
            KW_STATUS: w = "status";
            KW_FORMAT: w = "format";
            KW_FILE:   w = "file";
            KW_HELP:   w = "help";
            default:   w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_SEL_W-1:0] k,
                                                  input logic [IDX_W-1:0]    i);
        logic [KW_LEN_MAX*CHAR_W-1:0] w;
        logic [IDX_W-1:0]             l;
        logic [CHAR_W-1:0]            c;
        w = kw_word(k);
        l = kw_len(k);
        c = '0;
        for (int p = 0; p < KW_LEN_MAX; p++) begin
            if (IDX_W'(p) == i && i < l) begin
                c = w[CHAR_W*(KW_LEN_MAX-1-p) +: CHAR_W];
            end
        end
        // Shift out the unused leading bytes of shorter words
        if (i < l) begin
            c = w[CHAR_W*(int'(l)-1-int'(i)) +: CHAR_W];
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/lkcm_token_ram.sv
module lkcm_token_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [lkcm_pkg::IDX_W-1:0] i_waddr,
    input  logic [lkcm_pkg::CHAR_W-1:0] i_wdata,
    input  logic [lkcm_pkg::IDX_W-1:0] i_raddr,
    output logic [lkcm_pkg::CHAR_W-1:0] o_rdata
);

    logic [lkcm_pkg::CHAR_W-1:0] r_mem [lkcm_pkg::TOKEN_DEPTH];
    logic [lkcm_pkg::CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lkcm_kw_cmp.sv
module lkcm_kw_cmp (
    input  logic                       i_clk,
    input  lkcm_pkg::t_cmp_ctl         i_ctl,
    output logic [lkcm_pkg::CMD_W-1:0] o_cmd
);

    logic [lkcm_pkg::NUM_KW-1:0] r_match;
    logic [lkcm_pkg::NUM_KW-1:0] n_match;

    always_comb begin
        n_match = r_match;
        for (int k = 0; k < lkcm_pkg::NUM_KW; k++) begin
            if (i_ctl.start) begin
                n_match[k] = (lkcm_pkg::kw_len(lkcm_pkg::KW_SEL_W'(k)) == i_ctl.len);
            end else if (i_ctl.step) begin
                n_match[k] = r_match[k] &
                    (i_ctl.data == lkcm_pkg::kw_char(lkcm_pkg::KW_SEL_W'(k), i_ctl.idx));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
    end

    // First matching keyword wins; its code is its position plus one
    always_comb begin
        o_cmd = lkcm_pkg::CMD_UNKNOWN;
        for (int k = lkcm_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (r_match[k]) begin
                o_cmd = lkcm_pkg::CMD_W'(k + 1);
            end
        end
    end

endmodule

FILE: rtl/core/line_keyword_command_matcher.sv
// Command-line keyword matcher. Each input transaction carries one received
// character; NUL and carriage return are dropped, other non-terminators are
// stored in a 40-entry token buffer (the write index wraps, keeping only the
// characters since the wrap) while the block stays ready for the next one. A
// newline or space ends the token. With argument mode off the token is
// compared against start, stop, status, format, help and file, each character
// first read from the buffer and then compared, then one command result
// (last = 1) is sent; unknown if nothing matches, and file sends nothing but
// marks a file command as pending. With argument mode on, every token
// character is sent as an argument transaction (tuser = 1), then the pending
// command (file, or none before file was seen). A space turns argument mode
// on. The character scan runs only when the token has a keyword's length (4
// to 6 characters); other command tokens are sent as unknown directly. While
// a terminator is processed, including any wait while the output register is
// full, s_axis_tready stays low; the longest token holds 39 characters.
// Results leave through a single output register.
module line_keyword_command_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] command, [10:3] arg_char, [15:11] zero
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CMP_RD   = 3'd1;
    localparam logic [2:0] S_CMP      = 3'd2;
    localparam logic [2:0] S_CMP_DONE = 3'd3;
    localparam logic [2:0] S_ARG_RD   = 3'd4;
    localparam logic [2:0] S_ARG_EMIT = 3'd5;
    localparam logic [2:0] S_EMIT_CMD = 3'd6;

    logic [2:0]                         r_state, n_state;
    logic [lkcm_pkg::IDX_W-1:0]         r_widx, n_widx;
    logic [lkcm_pkg::IDX_W-1:0]         r_len, n_len;
    logic [lkcm_pkg::IDX_W-1:0]         r_idx, n_idx;
    logic                               r_space, n_space;
    logic                               r_arg_mode, n_arg_mode;
    logic                               r_file_pend, n_file_pend;
    logic [lkcm_pkg::CMD_W-1:0]         r_cmd, n_cmd;
    logic                               r_out_valid, n_out_valid;
    logic                               r_out_kind, n_out_kind;
    logic [lkcm_pkg::CMD_W-1:0]         r_out_cmd, n_out_cmd;
    logic [lkcm_pkg::CHAR_W-1:0]        r_out_char, n_out_char;
    logic                               r_out_last, n_out_last;

    logic                               in_fire;
    logic                               out_free;
    logic                               ram_we;
    logic [lkcm_pkg::CHAR_W-1:0]        ram_rdata;
    logic [lkcm_pkg::CHAR_W-1:0]        ch;
    lkcm_pkg::t_cmp_ctl                 cmp_ctl;
    logic [lkcm_pkg::CMD_W-1:0]         cmp_cmd;

    assign ch            = s_axis_tdata;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~r_out_valid | m_axis_tready;

    lkcm_token_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx),
        .i_wdata (ch),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    lkcm_kw_cmp u_cmp (
        .i_clk (i_clk),
        .i_ctl (cmp_ctl),
        .o_cmd (cmp_cmd)
    );

    always_comb begin
        n_state     = r_state;
        n_widx      = r_widx;
        n_len       = r_len;
        n_idx       = r_idx;
        n_space     = r_space;
        n_arg_mode  = r_arg_mode;
        n_file_pend = r_file_pend;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_cmd   = r_out_cmd;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        cmp_ctl       = '0;
        cmp_ctl.len   = r_widx;
        cmp_ctl.idx   = r_idx;
        cmp_ctl.data  = ram_rdata;

        case (r_state)
            S_IDLE: begin
                if (in_fire && ch != lkcm_pkg::CH_NUL && ch != lkcm_pkg::CH_CR) begin
                    if (ch != lkcm_pkg::CH_LF && ch != lkcm_pkg::CH_SP) begin
                        ram_we = 1'b1;
                        if (r_widx == lkcm_pkg::IDX_W'(lkcm_pkg::TOKEN_DEPTH - 1)) begin
                            n_widx = '0;
                        end else begin
                            n_widx = r_widx + lkcm_pkg::IDX_W'(1);
                        end
                    end else begin
                        n_len   = r_widx;
                        n_widx  = '0;
                        n_idx   = '0;
                        n_space = (ch == lkcm_pkg::CH_SP);
                        if (r_arg_mode) begin
                            n_state = S_ARG_RD;
                        end else begin
                            cmp_ctl.start = 1'b1;
                            // Only lengths a keyword can have need the character scan
                            if (r_widx inside {[lkcm_pkg::KW_LEN_MIN:lkcm_pkg::KW_LEN_MAX]}) begin
                                n_state = S_CMP_RD;
                            end else begin
                                n_state = S_CMP_DONE;
                            end
                        end
                    end
                end
            end
            S_CMP_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                cmp_ctl.step = 1'b1;
                n_idx        = r_idx + lkcm_pkg::IDX_W'(1);
                if (r_idx + lkcm_pkg::IDX_W'(1) == r_len) begin
                    n_state = S_CMP_DONE;
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_CMP_DONE: begin
                if (cmp_cmd == lkcm_pkg::CMD_FILE) begin
                    n_file_pend = 1'b1;
                    n_arg_mode  = r_space;
                    n_state     = S_IDLE;
                end else begin
                    n_cmd   = cmp_cmd;
                    n_state = S_EMIT_CMD;
                end
            end
            S_ARG_RD: begin
                if (r_idx == r_len) begin
                    n_cmd   = r_file_pend ? lkcm_pkg::CMD_FILE : lkcm_pkg::CMD_NONE;
                    n_state = S_EMIT_CMD;
                end else begin
                    n_state = S_ARG_EMIT;
                end
            end
            S_ARG_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b1;
                    n_out_cmd   = lkcm_pkg::CMD_NONE;
                    n_out_char  = ram_rdata;
                    n_out_last  = 1'b0;
                    n_idx       = r_idx + lkcm_pkg::IDX_W'(1);
                    n_state     = S_ARG_RD;
                end
            end
            S_EMIT_CMD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b0;
                    n_out_cmd   = r_cmd;
                    n_out_char  = '0;
                    n_out_last  = 1'b1;
                    n_arg_mode  = r_space;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_idx       <= '0;
            r_arg_mode  <= 1'b0;
            r_file_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_widx      <= n_widx;
            r_idx       <= n_idx;
            r_arg_mode  <= n_arg_mode;
            r_file_pend <= n_file_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_space    <= n_space;
        r_cmd      <= n_cmd;
        r_out_kind <= n_out_kind;
        r_out_cmd  <= n_out_cmd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_char, r_out_cmd};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule
